@@ src/bresenham_line_rasterizer_macros.svh @@
// Assertion macros shared by the line rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define BRL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("line rasterizer check failed");

// Next-cycle implication.
`define BRL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("line rasterizer check failed");

`endif

@@ src/brl_pkg.sv @@
// Types and constants shared by the line rasterizer modules.
`timescale 1ns / 1ps
package brl_pkg;

  localparam int X_W       = 6;
  localparam int Y_W       = 5;
  localparam int ERR_W     = 10;
  localparam int CMP_W     = 7;
  localparam int CMD_DEPTH = 2;

  typedef struct packed {
    logic [X_W-1:0]          x;
    logic [Y_W-1:0]          y;
    logic [X_W-1:0]          xe;
    logic [Y_W-1:0]          ye;
    logic [X_W-1:0]          dx;
    logic [Y_W-1:0]          dy;
    logic                    sx_neg;
    logic                    sy_neg;
    logic signed [ERR_W-1:0] err;
  } cmd_t;

endpackage

@@ src/brl_front.sv @@
// Front end: turns a line command into deltas, step directions and initial error.
`timescale 1ns / 1ps
module brl_front (
  input  logic [brl_pkg::X_W-1:0] start_x,
  input  logic [brl_pkg::Y_W-1:0] start_y,
  input  logic [brl_pkg::X_W-1:0] end_x,
  input  logic [brl_pkg::Y_W-1:0] end_y,
  output brl_pkg::cmd_t           cmd
);
  import brl_pkg::*;

  logic [X_W-1:0] dx;
  logic [Y_W-1:0] dy;

  assign dx = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
  assign dy = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);

  always_comb begin
    cmd.x      = start_x;
    cmd.y      = start_y;
    cmd.xe     = end_x;
    cmd.ye     = end_y;
    cmd.dx     = dx;
    cmd.dy     = dy;
    cmd.sx_neg = !(start_x < end_x);
    cmd.sy_neg = !(start_y < end_y);
    cmd.err    = signed'(ERR_W'(dx)) - signed'(ERR_W'(dy));
  end

endmodule

@@ src/brl_cmd_fifo.sv @@
// Short command queue between the front end and the stepper.
`timescale 1ns / 1ps
module brl_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  brl_pkg::cmd_t wr_data,
  input  logic          rd,
  output brl_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import brl_pkg::*;

  localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem [CMD_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ src/brl_stepper.sv @@
// Back end: Bresenham walk of a line, one pixel per cycle unless stalled, output reg.
`timescale 1ns / 1ps
module brl_stepper #(
  parameter int CANVAS_WIDTH  = 64,
  parameter int CANVAS_HEIGHT = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  brl_pkg::cmd_t           cmd,
  input  logic                    cmd_empty,
  output logic                    cmd_pop,
  output logic [brl_pkg::X_W-1:0] pixel_x,
  output logic [brl_pkg::Y_W-1:0] pixel_y,
  output logic                    last_pixel,
  output logic                    empty,
  input  logic                    pop
);
  import brl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } step_state_t;

  step_state_t             state;
  step_state_t             state_next;
  logic [X_W-1:0]          x;
  logic [Y_W-1:0]          y;
  logic [X_W-1:0]          xe;
  logic [Y_W-1:0]          ye;
  logic [X_W-1:0]          dx;
  logic [Y_W-1:0]          dy;
  logic                    sx_neg;
  logic                    sy_neg;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] err_next;
  logic signed [ERR_W-1:0] dxs;
  logic signed [ERR_W-1:0] dys;
  logic signed [ERR_W-1:0] twice;
  logic                    out_valid;
  logic                    out_valid_next;
  logic                    step_x;
  logic                    step_y;
  logic                    at_end;
  logic                    in_canvas;
  logic                    adv;
  logic                    emit;
  logic                    load;

  assign dxs       = signed'(ERR_W'(dx));
  assign dys       = signed'(ERR_W'(dy));
  assign twice     = err <<< 1;
  assign step_x    = twice > -dys;
  assign step_y    = twice < dxs;
  assign err_next  = err - (step_x ? dys : '0) + (step_y ? dxs : '0);
  assign at_end    = (x == xe) && (y == ye);
  assign in_canvas = (CMP_W'(x) < CMP_W'(CANVAS_WIDTH)) &&
                     (CMP_W'(y) < CMP_W'(CANVAS_HEIGHT));

  assign adv     = (state == ST_WALK) && (!out_valid || pop);
  assign emit    = adv && in_canvas;
  assign load    = (state == ST_IDLE) && !cmd_empty;
  assign cmd_pop = load;
  assign empty   = !out_valid;

  always_comb begin
    state_next     = state;
    out_valid_next = (out_valid && !pop) || emit;
    case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (adv && at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x      <= cmd.x;
      y      <= cmd.y;
      xe     <= cmd.xe;
      ye     <= cmd.ye;
      dx     <= cmd.dx;
      dy     <= cmd.dy;
      sx_neg <= cmd.sx_neg;
      sy_neg <= cmd.sy_neg;
      err    <= cmd.err;
    end else if (adv && !at_end) begin
      err <= err_next;
      if (step_x) begin
        x <= sx_neg ? x - X_W'(1) : x + X_W'(1);
      end
      if (step_y) begin
        y <= sy_neg ? y - Y_W'(1) : y + Y_W'(1);
      end
    end
    if (emit) begin
      pixel_x    <= x;
      pixel_y    <= y;
      last_pixel <= at_end;
    end
  end

endmodule

@@ src/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer.
//
// Input queue side: a line command (start_x, start_y, end_x, end_y) is taken
// at a clock edge with push high and full low. Commands land in a two-entry
// command queue, so up to two lines can wait while the stepper walks another.
// Result queue side: while empty is low, pixel_x, pixel_y and last_pixel show
// the oldest pixel; it is taken at an edge with pop high.
// A line visits max(|dx|,|dy|)+1 pixels in order from start to end; pixels
// off the CANVAS_WIDTH x CANVAS_HEIGHT canvas are dropped. last_pixel marks
// the end point when it is on the canvas.
// The first pixel of a command passes the command queue, the stepper's load
// into its walk registers and the pixel output register. The stepper produces
// one pixel per cycle while pop does not stall it, and loads each command in
// its idle state before walking it, so a new line waits until the last is done.
// A stalled pop holds the stepper in place; the command queue keeps taking
// lines until it fills. Synchronous reset empties both queues and idles the
// stepper.
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_macros.svh"
module bresenham_line_rasterizer #(
  parameter int CANVAS_WIDTH  = 64,
  parameter int CANVAS_HEIGHT = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [brl_pkg::X_W-1:0] start_x,
  input  logic [brl_pkg::Y_W-1:0] start_y,
  input  logic [brl_pkg::X_W-1:0] end_x,
  input  logic [brl_pkg::Y_W-1:0] end_y,
  output logic                    empty,
  input  logic                    pop,
  output logic [brl_pkg::X_W-1:0] pixel_x,
  output logic [brl_pkg::Y_W-1:0] pixel_y,
  output logic                    last_pixel
);
  import brl_pkg::*;

  cmd_t front_cmd;
  cmd_t queued_cmd;
  logic cmd_empty;
  logic cmd_pop;

  brl_front u_front (
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .cmd     (front_cmd)
  );

  brl_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_cmd),
    .rd      (cmd_pop),
    .rd_data (queued_cmd),
    .full    (full),
    .empty   (cmd_empty)
  );

  brl_stepper #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_stepper (
    .clk        (clk),
    .rst        (rst),
    .cmd        (queued_cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel),
    .empty      (empty),
    .pop        (pop)
  );

  `BRL_ASSERT_NOW(a_queue_flags, full, !cmd_empty)
  `BRL_ASSERT_NOW(a_no_pop_when_empty, cmd_pop, !cmd_empty)
  `BRL_ASSERT_NOW(a_pixel_on_canvas, !empty,
                  (CMP_W'(pixel_x) < CMP_W'(CANVAS_WIDTH)) &&
                  (CMP_W'(pixel_y) < CMP_W'(CANVAS_HEIGHT)))
  `BRL_ASSERT_NEXT(a_push_fills_queue, push && !full, !cmd_empty || !empty)

endmodule

@@ dv/tb_bresenham_line_rasterizer.sv @@
// Self-checking testbench for the Bresenham line rasterizer top level.
`timescale 1ns / 1ps
module tb_bresenham_line_rasterizer;

  localparam int CANVAS_W    = 64;
  localparam int CANVAS_H    = 32;
  localparam int MAX_PIXELS  = 64;
  localparam int WALK_MAX    = 256;
  localparam int RAND_LINES  = 320;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [brl_pkg::X_W-1:0] x0;
    logic [brl_pkg::Y_W-1:0] y0;
    logic [brl_pkg::X_W-1:0] x1;
    logic [brl_pkg::Y_W-1:0] y1;
  } line_t;

  typedef struct packed {
    logic [brl_pkg::X_W-1:0] x;
    logic [brl_pkg::Y_W-1:0] y;
    logic                    last;
  } pixel_t;

  logic                    clk;
  logic                    rst;
  logic                    push;
  logic                    full;
  logic [brl_pkg::X_W-1:0] start_x;
  logic [brl_pkg::Y_W-1:0] start_y;
  logic [brl_pkg::X_W-1:0] end_x;
  logic [brl_pkg::Y_W-1:0] end_y;
  logic                    empty;
  logic                    pop;
  logic [brl_pkg::X_W-1:0] pixel_x;
  logic [brl_pkg::Y_W-1:0] pixel_y;
  logic                    last_pixel;

  line_t  line_q[$];
  pixel_t pixel_q[$];
  line_t  next_line;
  pixel_t want;
  int     n_lines;
  int     n_taken;
  int     n_pixels;
  int     errors;
  int     burst_left;
  int     gap_left;
  int     stall_mode;
  int     mode_left;
  int     cycle_cnt;

  bresenham_line_rasterizer #(
    .CANVAS_WIDTH (CANVAS_W),
    .CANVAS_HEIGHT(CANVAS_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .empty     (empty),
    .pop       (pop),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last_pixel(last_pixel)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Walk the line and queue every on-canvas pixel it visits.
  function automatic void rasterize_line(input line_t ln);
    int     x, y, xe, ye, dx, dy, sx, sy, err, twice, n, steps;
    bit     at_end, done;
    pixel_t px;
    x  = ln.x0;
    y  = ln.y0;
    xe = ln.x1;
    ye = ln.y1;
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = dx - dy;
    n = 0;
    done = 1'b0;
    for (steps = 0; steps < WALK_MAX && !done; steps++) begin
      at_end = (x == xe) && (y == ye);
      if (x >= 0 && x < CANVAS_W && y >= 0 && y < CANVAS_H && n < MAX_PIXELS) begin
        px.x    = x[brl_pkg::X_W-1:0];
        px.y    = y[brl_pkg::Y_W-1:0];
        px.last = at_end;
        pixel_q.push_back(px);
        n++;
      end
      if (at_end) begin
        done = 1'b1;
      end else begin
        twice = 2 * err;
        if (twice > -dy) begin
          err -= dy;
          x += sx;
        end
        if (twice < dx) begin
          err += dx;
          y += sy;
        end
      end
    end
  endfunction

  function automatic line_t make_line(input int x0, input int y0, input int x1, input int y1);
    line_t ln;
    ln.x0 = x0[brl_pkg::X_W-1:0];
    ln.y0 = y0[brl_pkg::Y_W-1:0];
    ln.x1 = x1[brl_pkg::X_W-1:0];
    ln.y1 = y1[brl_pkg::Y_W-1:0];
    return ln;
  endfunction

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Driver: bursts of items from line_q with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (push && !full) begin
        rasterize_line({start_x, start_y, end_x, end_y});
        n_taken++;
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          push     <= 1'b0;
        end else if (line_q.size() > 0) begin
          next_line = line_q.pop_front();
          push    <= 1'b1;
          start_x <= next_line.x0;
          start_y <= next_line.y0;
          end_x   <= next_line.x1;
          end_y   <= next_line.y1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            case ($urandom_range(3, 0))
              0: gap_left <= 0;
              1: gap_left <= $urandom_range(3, 1);
              2: gap_left <= $urandom_range(10, 1);
              default: gap_left <= $urandom_range(80, 20);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped pixel; pop on a mode-switching stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (pop && !empty) begin
        n_pixels++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel: x=%0d y=%0d last=%0d", pixel_x, pixel_y, last_pixel);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
            errors++;
          end
          if (pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
            errors++;
          end
          if (last_pixel !== want.last) begin
            $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(3, 0);
        mode_left  <= $urandom_range(256, 32);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(1, 0) == 1);
        2: pop <= ($urandom_range(3, 0) == 0);
        default: pop <= ($urandom_range(15, 0) < 13);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_bresenham_line_rasterizer: FAIL");
      $finish;
    end
  end

  initial begin
    int i, kind, x0, y0;
    rst       = 1'b1;
    push      = 1'b0;
    pop       = 1'b0;
    start_x   = '0;
    start_y   = '0;
    end_x     = '0;
    end_y     = '0;
    n_taken   = 0;
    n_pixels  = 0;
    errors    = 0;
    cycle_cnt = 0;

    // directed: degenerate lines, canvas extremes, every octant, axis lines
    line_q.push_back(make_line(0, 0, 0, 0));
    line_q.push_back(make_line(63, 31, 63, 31));
    line_q.push_back(make_line(0, 0, 63, 31));
    line_q.push_back(make_line(63, 31, 0, 0));
    line_q.push_back(make_line(0, 31, 63, 0));
    line_q.push_back(make_line(0, 5, 63, 5));
    line_q.push_back(make_line(63, 0, 0, 0));
    line_q.push_back(make_line(10, 0, 10, 31));
    line_q.push_back(make_line(10, 31, 10, 0));
    line_q.push_back(make_line(32, 16, 40, 20));
    line_q.push_back(make_line(32, 16, 36, 24));
    line_q.push_back(make_line(32, 16, 28, 24));
    line_q.push_back(make_line(32, 16, 24, 20));
    line_q.push_back(make_line(32, 16, 24, 12));
    line_q.push_back(make_line(32, 16, 28, 8));
    line_q.push_back(make_line(32, 16, 36, 8));
    line_q.push_back(make_line(32, 16, 40, 12));
    line_q.push_back(make_line(0, 0, 31, 31));
    line_q.push_back(make_line(31, 0, 0, 31));
    line_q.push_back(make_line(0, 31, 1, 0));
    line_q.push_back(make_line(5, 5, 6, 6));
    line_q.push_back(make_line(0, 0, 1, 0));
    line_q.push_back(make_line(42, 21, 21, 10));

    for (i = 0; i < RAND_LINES; i++) begin
      kind = $urandom_range(9, 0);
      x0 = $urandom_range(63, 0);
      y0 = $urandom_range(31, 0);
      if (kind < 5) begin
        line_q.push_back(make_line(x0, y0, $urandom_range(63, 0), $urandom_range(31, 0)));
      end else if (kind < 8) begin
        line_q.push_back(make_line(x0, y0, clamp(x0 + $urandom_range(8, 0) - 4, 63),
                                   clamp(y0 + $urandom_range(8, 0) - 4, 31)));
      end else if (kind == 8) begin
        line_q.push_back(make_line(x0, y0, x0, y0));
      end else if ($urandom_range(1, 0)) begin
        line_q.push_back(make_line(x0, y0, $urandom_range(63, 0), y0));
      end else begin
        line_q.push_back(make_line(x0, y0, x0, $urandom_range(31, 0)));
      end
    end
    n_lines = line_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_lines || pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Rasterized %0d line commands under random bursts and pop stalls;", n_lines);
    $display("%0d pixels compared, %0d mismatches.", n_pixels, errors);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("tb_bresenham_line_rasterizer: PASS");
    end else begin
      $display("tb_bresenham_line_rasterizer: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/brl_pkg.sv
src/brl_front.sv
src/brl_cmd_fifo.sv
src/brl_stepper.sv
src/bresenham_line_rasterizer.sv
dv/tb_bresenham_line_rasterizer.sv
